### src/ste_pkg.sv
// shared constants, codes and control types for the sorted table engine
package ste_pkg;

  // default sizes
  localparam int DEPTH_DEF       = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // operation codes of the kind field
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // relation codes, two's complement
  localparam logic [1:0] REL_EQ     = 2'b00;
  localparam logic [1:0] REL_BEFORE = 2'b01;
  localparam logic [1:0] REL_AFTER  = 2'b11;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_MID,
    OP_STEP,
    OP_WRITE_VAL,
    OP_UP_PRIME,
    OP_UP_MOVE,
    OP_WRITE_NEW,
    OP_DN_PRIME,
    OP_DN_MOVE,
    OP_DEC
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e  op;
    logic    publish;
    status_e status;
    logic    pub_value;
  } ste_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_remove;
    logic no_replace;
    logic cnt_zero;
    logic full;
    logic key_eq;
    logic key_lt;
    logic at_lo;
    logic at_hi;
    logic hit;
    logic up_none;
    logic dn_done;
  } ste_sts_t;

endpackage

### src/ste_dp.sv
// datapath: entry memory, search bounds, shift index, count and result registers
module ste_dp #(
  parameter int DEPTH       = ste_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = ste_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = ste_pkg::VALUE_WIDTH_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ste_pkg::ste_cmd_t      cmd_i,
  output ste_pkg::ste_sts_t      sts_o,
  input  logic [1:0]             kind_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   no_replace_i,
  output logic [1:0]             status_o,
  output logic [CW-1:0]          position_o,
  output logic signed [1:0]      relation_o,
  output logic [VALUE_WIDTH-1:0] value_out_o,
  output logic [CW-1:0]          count_o
);
  import ste_pkg::*;

  localparam int EW = KEY_WIDTH + VALUE_WIDTH;

  // entry memory, key in the upper bits
  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rdata_q;

  // latched transaction
  logic [1:0]             kind_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   nrep_q;

  // search and shift state
  logic [IW-1:0]          lo_q, hi_q, pos_q, idx_q;
  logic [1:0]             rel_q;
  logic [VALUE_WIDTH-1:0] hitv_q;
  logic [CW-1:0]          cnt_q;

  // result registers
  logic [1:0]             res_status_q;
  logic [CW-1:0]          res_pos_q;
  logic [1:0]             res_rel_q;
  logic [VALUE_WIDTH-1:0] res_val_q;
  logic [CW-1:0]          res_cnt_q;

  logic [IW:0]            sum;
  logic [IW-1:0]          mid;
  logic [KEY_WIDTH-1:0]   rkey;
  logic [IW-1:0]          raddr;
  logic                   wen;
  logic [IW-1:0]          waddr;
  logic [EW-1:0]          wdata;
  logic [CW-1:0]          idx_next;

  // probe point and compare against the registered read
  assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = sum[IW:1];
  assign rkey     = rdata_q[EW-1:VALUE_WIDTH];
  assign idx_next = CW'(idx_q) + CW'(1);

  // status to controller
  always_comb begin
    sts_o.is_insert  = (kind_q == KIND_INSERT);
    sts_o.is_remove  = (kind_q == KIND_REMOVE);
    sts_o.no_replace = nrep_q;
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.full       = (cnt_q == CW'(DEPTH));
    sts_o.key_eq     = (rkey == key_q);
    sts_o.key_lt     = (key_q < rkey);
    sts_o.at_lo      = (mid == lo_q);
    sts_o.at_hi      = (mid == hi_q);
    sts_o.hit        = (rel_q == REL_EQ);
    sts_o.up_none    = (idx_q == pos_q);
    sts_o.dn_done    = (idx_next >= cnt_q);
  end

  // memory address and write selection
  always_comb begin
    raddr = mid;
    wen   = 1'b0;
    waddr = pos_q;
    wdata = {key_q, val_q};
    unique case (cmd_i.op)
      OP_UP_PRIME: raddr = IW'(cnt_q - CW'(1));
      OP_UP_MOVE: begin
        raddr = idx_q - IW'(2);
        wen   = 1'b1;
        waddr = idx_q;
        wdata = rdata_q;
      end
      OP_DN_PRIME: raddr = pos_q + IW'(1);
      OP_DN_MOVE: begin
        raddr = idx_q + IW'(2);
        wen   = 1'b1;
        waddr = idx_q;
        wdata = rdata_q;
      end
      OP_WRITE_VAL, OP_WRITE_NEW: wen = 1'b1;
      default: ;
    endcase
  end

  // entry memory with registered read
  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.op == OP_WRITE_NEW) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.op == OP_DEC) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // transaction, search and shift registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        kind_q <= kind_i;
        key_q  <= key_i;
        val_q  <= value_i;
        nrep_q <= no_replace_i;
        lo_q   <= '0;
        hi_q   <= IW'(cnt_q - CW'(1));
        pos_q  <= '0;
        rel_q  <= REL_EQ;
      end
      OP_STEP: begin
        pos_q  <= mid;
        hitv_q <= rdata_q[VALUE_WIDTH-1:0];
        if (rkey == key_q) begin
          rel_q <= REL_EQ;
        end else if (key_q < rkey) begin
          rel_q <= REL_BEFORE;
          hi_q  <= mid - IW'(1);
        end else begin
          rel_q <= REL_AFTER;
          lo_q  <= mid + IW'(1);
        end
      end
      OP_UP_PRIME: begin
        if (rel_q == REL_AFTER) begin
          pos_q <= pos_q + IW'(1);
        end
        idx_q <= IW'(cnt_q);
      end
      OP_UP_MOVE:   idx_q <= idx_q - IW'(1);
      OP_WRITE_NEW: rel_q <= REL_EQ;
      OP_DN_PRIME:  idx_q <= pos_q;
      OP_DN_MOVE:   idx_q <= idx_q + IW'(1);
      default: ;
    endcase
  end

  // result registers, loaded when the controller publishes
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      res_status_q <= cmd_i.status;
      res_pos_q    <= CW'(pos_q);
      res_rel_q    <= rel_q;
      res_val_q    <= cmd_i.pub_value ? hitv_q : '0;
      res_cnt_q    <= cnt_q;
    end
  end

  assign status_o    = res_status_q;
  assign position_o  = res_pos_q;
  assign relation_o  = $signed(res_rel_q);
  assign value_out_o = res_val_q;
  assign count_o     = res_cnt_q;

endmodule

### src/ste_ctrl.sv
// controller: sequences search, update, shift and result handoff
module ste_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  ste_pkg::ste_sts_t sts_i,
  output ste_pkg::ste_cmd_t cmd_o
);
  import ste_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_CMP,
    S_ACT,
    S_UP,
    S_DN,
    S_PUB
  } state_e;

  state_e  state_q, state_d;
  status_e stat_q, stat_d;
  logic    vout_q, vout_d;
  logic    out_valid_q, out_valid_d;
  logic    probe_done;

  assign probe_done = sts_i.key_eq || (sts_i.key_lt && sts_i.at_lo) ||
                      (!sts_i.key_lt && sts_i.at_hi);

  // next state and datapath command
  always_comb begin
    state_d         = state_q;
    stat_d          = stat_q;
    vout_d          = vout_q;
    cmd_o.op        = OP_NONE;
    cmd_o.publish   = 1'b0;
    cmd_o.status    = stat_q;
    cmd_o.pub_value = vout_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          vout_d   = 1'b0;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (sts_i.cnt_zero) begin
          if (sts_i.is_insert) begin
            cmd_o.op = OP_UP_PRIME;
            state_d  = S_UP;
          end else begin
            stat_d  = ST_NOT_FOUND;
            state_d = S_PUB;
          end
        end else begin
          cmd_o.op = OP_READ_MID;
          state_d  = S_CMP;
        end
      end
      S_RD: begin
        cmd_o.op = OP_READ_MID;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_STEP;
        state_d  = probe_done ? S_ACT : S_RD;
      end
      S_ACT: begin
        if (sts_i.is_insert) begin
          if (sts_i.hit) begin
            if (sts_i.no_replace) begin
              stat_d = ST_EXISTS;
            end else begin
              cmd_o.op = OP_WRITE_VAL;
              stat_d   = ST_DONE;
            end
            state_d = S_PUB;
          end else if (sts_i.full) begin
            stat_d  = ST_FULL;
            state_d = S_PUB;
          end else begin
            cmd_o.op = OP_UP_PRIME;
            state_d  = S_UP;
          end
        end else if (sts_i.is_remove) begin
          if (sts_i.hit) begin
            cmd_o.op = OP_DN_PRIME;
            state_d  = S_DN;
          end else begin
            stat_d  = ST_NOT_FOUND;
            state_d = S_PUB;
          end
        end else begin
          stat_d  = sts_i.hit ? ST_DONE : ST_NOT_FOUND;
          vout_d  = sts_i.hit;
          state_d = S_PUB;
        end
      end
      S_UP: begin
        if (sts_i.up_none) begin
          cmd_o.op = OP_WRITE_NEW;
          stat_d   = ST_DONE;
          state_d  = S_PUB;
        end else begin
          cmd_o.op = OP_UP_MOVE;
        end
      end
      S_DN: begin
        if (sts_i.dn_done) begin
          cmd_o.op = OP_DEC;
          stat_d   = ST_DONE;
          state_d  = S_PUB;
        end else begin
          cmd_o.op = OP_DN_MOVE;
        end
      end
      S_PUB: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.publish ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stat_q      <= ST_DONE;
      vout_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stat_q      <= stat_d;
      vout_q      <= vout_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### src/sorted_table_engine.sv
// top level of the sorted key/value table engine
//
// Holds up to DEPTH key/value entries in ascending unsigned key order. Each
// input transaction (kind, key, value, no_replace) is a lookup, insert or
// remove; each produces exactly one result transaction (status, position,
// relation, value_out, count). Both channels use valid/stall: a transaction
// moves on a rising edge with valid high and stall low.
// The block takes one transaction at a time; in_stall_o is high from the
// cycle after acceptance until the result is placed in the output register.
// Binary search makes each probe as a memory read, then a compare, with
// at most clog2(count)+1 probes. An insert of a new key moves each later
// entry up one place, one entry per cycle through the single read port of
// the entry memory; a remove moves later entries down. The result is loaded
// once the search and any shift are complete.
// The output register holds the result while out_stall_i is high; a new
// transaction can be accepted meanwhile, and its result waits until the
// previous one has been taken.
// Reset clears the entry count and the handshake state; entry memory is not
// cleared and needs no clearing pass, only entries below the count are used.
module sorted_table_engine #(
  parameter int DEPTH       = ste_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = ste_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = ste_pkg::VALUE_WIDTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   no_replace_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [CW-1:0]          position_o,
  output logic signed [1:0]      relation_o,
  output logic [VALUE_WIDTH-1:0] value_out_o,
  output logic [CW-1:0]          count_o
);
  import ste_pkg::*;

  ste_cmd_t cmd;
  ste_sts_t sts;

  // sequencing
  ste_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  ste_dp #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .no_replace_i (no_replace_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .relation_o   (relation_o),
    .value_out_o  (value_out_o),
    .count_o      (count_o)
  );

endmodule

### bench/ste_checker.sv
// watches both channels of the sorted table engine, predicts each result and compares it
module ste_checker #(
  parameter int DEPTH       = ste_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = ste_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = ste_pkg::VALUE_WIDTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [1:0]             kind_i,
  input  logic [KEY_WIDTH-1:0]   key_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   no_replace_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [1:0]             status_i,
  input  logic [CW-1:0]          position_i,
  input  logic signed [1:0]      relation_i,
  input  logic [VALUE_WIDTH-1:0] value_out_i,
  input  logic [CW-1:0]          count_i,
  output int                     errors_o,
  output int                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ste_pkg::*;

  typedef struct packed {
    status_e                status;
    logic [CW-1:0]          position;
    logic [1:0]             relation;
    logic [VALUE_WIDTH-1:0] value_out;
    logic [CW-1:0]          count;
  } outcome_t;

  // shadow copy of the table
  logic [KEY_WIDTH-1:0]   shadow_keys [DEPTH];
  logic [VALUE_WIDTH-1:0] shadow_vals [DEPTH];
  int                     shadow_count;

  outcome_t outcome_q [$];

  // runs one operation on the shadow table and returns the outcome it must produce
  function automatic outcome_t apply_op(logic [1:0] kind, logic [KEY_WIDTH-1:0] key,
                                        logic [VALUE_WIDTH-1:0] val, logic no_repl);
    outcome_t   res;
    int         lo;
    int         hi;
    int         mid;
    int         slot;
    logic [1:0] rel;
    bit         located;
    res = '0;
    res.status = ST_DONE;
    rel = REL_EQ;
    slot = 0;
    // binary search over the occupied entries
    if (shadow_count != 0) begin
      lo = 0;
      hi = shadow_count - 1;
      located = 1'b0;
      while (!located) begin
        mid = (lo + hi) / 2;
        slot = mid;
        if (shadow_keys[mid] == key) begin
          rel = REL_EQ;
          located = 1'b1;
        end else if (key < shadow_keys[mid]) begin
          hi = mid - 1;
          if (hi < lo) begin
            rel = REL_BEFORE;
            located = 1'b1;
          end
        end else begin
          lo = mid + 1;
          if (lo > hi) begin
            rel = REL_AFTER;
            located = 1'b1;
          end
        end
      end
    end
    if (kind == KIND_INSERT) begin
      if (shadow_count != 0 && rel == REL_EQ) begin
        if (no_repl) res.status = ST_EXISTS;
        else shadow_vals[slot] = val;
      end else if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // open a slot by moving later entries up
        if (rel == REL_AFTER) slot++;
        for (int i = shadow_count; i > slot; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_vals[i] = shadow_vals[i-1];
        end
        shadow_keys[slot] = key;
        shadow_vals[slot] = val;
        shadow_count++;
        rel = REL_EQ;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_NOT_FOUND;
    end else if (rel != REL_EQ) begin
      res.status = ST_NOT_FOUND;
    end else if (kind == KIND_REMOVE) begin
      // close the gap by moving later entries down
      for (int i = slot; i + 1 < shadow_count; i++) begin
        shadow_keys[i] = shadow_keys[i+1];
        shadow_vals[i] = shadow_vals[i+1];
      end
      shadow_count--;
    end else begin
      res.value_out = shadow_vals[slot];
    end
    res.position = slot[CW-1:0];
    res.relation = rel;
    res.count = shadow_count[CW-1:0];
    return res;
  endfunction

  // predict on each input transaction, compare on each result transaction
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      outcome_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        outcome_q.push_back(apply_op(kind_i, key_i, value_i, no_replace_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("%0t: result with nothing pending: status %0d position %0d", $realtime,
                     status_i, position_i);
          end
        end else begin
          want = outcome_q.pop_front();
          if (status_i != want.status || position_i != want.position ||
              relation_i != want.relation || value_out_i != want.value_out ||
              count_i != want.count) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: mismatch exp/act status %0d/%0d position %0d/%0d",
                       $realtime, want.status, status_i, want.position, position_i);
              $display("  relation %0d/%0d value_out %h/%h count %0d/%0d",
                       $signed(want.relation), relation_i, want.value_out, value_out_i,
                       want.count, count_i);
            end
          end
        end
      end
    end
    pending_o = outcome_q.size();
  end

endmodule

### bench/testbench.sv
// stimulus, clock, reset and verdict for the sorted table engine
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ste_pkg::*;

  localparam int         CW         = $clog2(DEPTH_DEF + 1);
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int         POOL_SIZE  = 100;
  localparam int         PHASE_LEN  = 300;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 kind_i       = KIND_LOOKUP;
  logic [KEY_WIDTH_DEF-1:0]   key_i        = '0;
  logic [VALUE_WIDTH_DEF-1:0] value_i      = '0;
  logic                       no_replace_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [1:0]                 status_o;
  logic [CW-1:0]              position_o;
  logic signed [1:0]          relation_o;
  logic [VALUE_WIDTH_DEF-1:0] value_out_o;
  logic [CW-1:0]              count_o;

  int errors;
  int pending;

  // idle control shared by sender and receiver
  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  int hold_left = 0;

  logic [KEY_WIDTH_DEF-1:0] key_pool [POOL_SIZE];

  sorted_table_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .key_i, .value_i, .no_replace_i,
    .out_valid_o, .out_stall_i, .status_o, .position_o, .relation_o, .value_out_o, .count_o
  );

  ste_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .key_i, .value_i,
    .no_replace_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .position_i(position_o), .relation_i(relation_o), .value_out_i(value_out_o),
    .count_i(count_o), .errors_o(errors), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 36);
    end
  end

  // offer one transaction after an optional random gap, return once it is taken
  task automatic send_item(logic [1:0] kind, logic [KEY_WIDTH_DEF-1:0] key,
                           logic [VALUE_WIDTH_DEF-1:0] val, logic no_repl);
    if (!quiet) begin
      while ($urandom_range(99) < 36) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    key_i        <= key;
    value_i      <= val;
    no_replace_i <= no_repl;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int                       ins_w;
    int                       rem_w;
    int                       pick;
    logic [1:0]               kind;
    logic [KEY_WIDTH_DEF-1:0] key;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, replace and refuse, hits and misses
    send_item(KIND_LOOKUP, 32'h0000_0005, 32'h0, 1'b0);
    send_item(KIND_REMOVE, 32'h0000_0005, 32'h0, 1'b0);
    send_item(KIND_SPARE,  32'h0000_0005, 32'h0, 1'b0);
    send_item(KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0);
    send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0);
    send_item(KIND_INSERT, 32'h4000_0000, 32'h0000_0001, 1'b0);
    send_item(KIND_INSERT, 32'h8000_0000, 32'h1234_5678, 1'b0);
    send_item(KIND_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 1'b1);
    send_item(KIND_LOOKUP, 32'h8000_0000, 32'h0, 1'b0);
    send_item(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_item(KIND_LOOKUP, 32'h8000_0001, 32'h0, 1'b0);
    send_item(KIND_SPARE,  32'h0000_0000, 32'h0, 1'b0);
    send_item(KIND_REMOVE, 32'h0001_2345, 32'h0, 1'b0);
    send_item(KIND_REMOVE, 32'h0000_0000, 32'h0, 1'b0);
    send_item(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_item(KIND_REMOVE, 32'h4000_0000, 32'h0, 1'b0);
    send_item(KIND_REMOVE, 32'h8000_0000, 32'h0, 1'b0);
    send_item(KIND_INSERT, 32'h5555_5555, 32'h5555_5555, 1'b1);
    send_item(KIND_INSERT, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0);
    send_item(KIND_LOOKUP, 32'h5555_5555, 32'h0, 1'b0);

    // random phases: fill to full, mix, drain; keys mostly from a shared pool
    for (int p = 0; p < 6; p++) begin
      unique case (p)
        0, 3: begin
          ins_w = 60;
          rem_w = 12;
        end
        2, 4: begin
          ins_w = 12;
          rem_w = 65;
        end
        default: begin
          ins_w = 35;
          rem_w = 30;
        end
      endcase
      quiet = (p == 3);
      if (p == 1) hold_req = 1'b1;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = key_pool[3] + KEY_WIDTH_DEF'(1);
      repeat (PHASE_LEN) begin
        pick = $urandom_range(99);
        if (pick < ins_w) kind = KIND_INSERT;
        else if (pick < ins_w + rem_w) kind = KIND_REMOVE;
        else if (pick < 97) kind = KIND_LOOKUP;
        else kind = KIND_SPARE;
        if ($urandom_range(99) < 82) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else key = $urandom;
        send_item(kind, key, $urandom, $urandom_range(3) == 0);
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    // drain outstanding results, then watch for strays
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
